[rtl/ctf_pkg.sv]
// Shared constants and tables of the complementary tilt filter.
// Depends on nothing; every other file takes names from here by scope.
package ctf_pkg;

  localparam int IN_W       = 16;
  localparam int ANG_W      = 17;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_LIMIT  = 8'd1;

  localparam logic [CFG_DATA_W-1:0] GYRO_WEIGHT_RST = 16'd62259;
  localparam logic [CFG_DATA_W-1:0] TILT_LIMIT_RST  = 16'd11520;

  // Angle clamp, Q8.8 degrees.
  localparam int ANGLE_MAX = 46080;

  // CORDIC: inputs are scaled by 2^SCALE_SH; table is Q.ATAN_FRAC degrees.
  localparam int SCALE_SH  = 24;
  localparam int ATAN_FRAC = 20;

  // Gyro term: (|rate| * us + GYRO_ROUND) / 250000, done as a shift by
  // GYRO_PRE_SH and a reciprocal multiply for GYRO_DIV.
  localparam int          GYRO_ROUND    = 125000;
  localparam int          GYRO_PRE_SH   = 4;
  localparam int          GYRO_DIV      = 15625;
  localparam logic [28:0] GYRO_RECIP    = 29'd281474976;
  localparam int          GYRO_RECIP_SH = 42;

  // atan(2^-i) in Q.20 degrees.
  function automatic int atan_q20(input int i);
    int v;
    case (i)
      0:       v = 47185920;
      1:       v = 27855475;
      2:       v = 14718068;
      3:       v = 7471121;
      4:       v = 3750058;
      5:       v = 1876857;
      6:       v = 938658;
      7:       v = 469357;
      8:       v = 234682;
      9:       v = 117342;
      10:      v = 58671;
      11:      v = 29335;
      12:      v = 14668;
      13:      v = 7334;
      14:      v = 3667;
      15:      v = 1833;
      16:      v = 917;
      17:      v = 458;
      18:      v = 229;
      19:      v = 115;
      20:      v = 57;
      21:      v = 29;
      22:      v = 14;
      23:      v = 7;
      default: v = 0;
    endcase
    return v;
  endfunction

endpackage

[rtl/ctf_in_if.sv]
// Input request channel: one IMU sample per request.
// Depends on ctf_pkg for field widths.
interface ctf_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [ctf_pkg::IN_W-1:0]   accel_x;
  logic signed [ctf_pkg::IN_W-1:0]   accel_y;
  logic signed [ctf_pkg::IN_W-1:0]   accel_z;
  logic signed [ctf_pkg::IN_W-1:0]   roll_rate;
  logic signed [ctf_pkg::IN_W-1:0]   pitch_rate;
  logic        [ctf_pkg::IN_W-1:0]   elapsed_us;

  modport source (output valid, accel_x, accel_y, accel_z, roll_rate, pitch_rate,
                  elapsed_us, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, roll_rate, pitch_rate,
                  elapsed_us, output ready);
endinterface

[rtl/ctf_out_if.sv]
// Result channel: filtered angles and the tilt alarm.
// Depends on ctf_pkg for field widths.
interface ctf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ctf_pkg::ANG_W-1:0]   roll_angle;
  logic signed [ctf_pkg::ANG_W-1:0]   pitch_angle;
  logic                               tilt_alarm;

  modport source (output valid, roll_angle, pitch_angle, tilt_alarm, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, tilt_alarm, output ready);
endinterface

[rtl/ctf_cfg_if.sv]
// Configuration write channel: register index and write data.
// Depends on ctf_pkg for widths.
interface ctf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ctf_pkg::CFG_IDX_W-1:0]     reg_index;
  logic [ctf_pkg::CFG_DATA_W-1:0]    wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[rtl/complementary_tilt_filter_unit.sv]
// Complementary tilt filter: roll/pitch from one IMU sample per request.
// Path: input register, the row of CORDIC cells, the two blend stages (multiply,
// then estimate register), then the output register; one sample in flight, and a
// new request is taken once the previous result moves into the output register.
// Reset (rst_n low, synchronous): clears both estimates and all valid state,
// restores gyro_weight and tilt_limit to their defaults.
module complementary_tilt_filter_unit #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  ctf_in_if.sink      in_chan,
  ctf_out_if.source   out_chan,
  ctf_cfg_if.sink     cfg_chan
);

  localparam int N     = CORDIC_STEPS;
  localparam int CW    = 43;                      // 16-bit sample << 24 plus growth
  localparam int ZW    = ANGLE_FRAC_BITS + 10;    // about +-190 degrees plus margin
  localparam int ZXW   = ZW + 8;
  localparam int PADW  = CW - ctf_pkg::IN_W - ctf_pkg::SCALE_SH;
  localparam int S_DN  = (ANGLE_FRAC_BITS >= 8) ? ANGLE_FRAC_BITS - 8 : 0;
  localparam int S_UP  = (ANGLE_FRAC_BITS >= 8) ? 0 : 8 - ANGLE_FRAC_BITS;
  localparam int HALF  = (S_DN > 0) ? (1 << (S_DN - 1)) : 0;
  localparam logic signed [ZW-1:0] Z90 = ZW'(90 << ANGLE_FRAC_BITS);

  localparam int AW = ctf_pkg::ANG_W;

  // ---------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while idle (the block does not enforce it); always ready.
  // ---------------------------------------------------------------------
  logic [ctf_pkg::CFG_DATA_W-1:0] gyro_weight_r, tilt_limit_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_weight_r <= ctf_pkg::GYRO_WEIGHT_RST;
      tilt_limit_r  <= ctf_pkg::TILT_LIMIT_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.reg_index)
        ctf_pkg::REG_GYRO_WEIGHT: gyro_weight_r <= cfg_chan.wdata;
        ctf_pkg::REG_TILT_LIMIT:  tilt_limit_r  <= cfg_chan.wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Request control: one sample in flight. busy_r drops when the result
  // moves into the output register, so a new request may enter while the
  // previous result still waits there.
  // ---------------------------------------------------------------------
  logic busy_r, res_pend_r;
  logic in_acc, out_load;

  assign in_chan.ready = !busy_r;
  assign in_acc        = in_chan.valid && !busy_r;

  // Lane 0 is roll (atan2(ay, az)), lane 1 is pitch (atan2(ax, az)).
  logic signed [ctf_pkg::IN_W-1:0] lane_x   [2];
  logic signed [ctf_pkg::IN_W-1:0] lane_y   [2];
  logic signed [ctf_pkg::IN_W-1:0] lane_rate[2];

  assign lane_x[0]    = in_chan.accel_z;
  assign lane_y[0]    = in_chan.accel_y;
  assign lane_x[1]    = in_chan.accel_z;
  assign lane_y[1]    = in_chan.accel_x;
  assign lane_rate[0] = in_chan.roll_rate;
  assign lane_rate[1] = in_chan.pitch_rate;

  // Hold the gyro operands for the whole request; the gyro pipeline
  // settles well before the CORDIC row drains.
  logic signed [ctf_pkg::IN_W-1:0] rate_r[2];
  logic        [ctf_pkg::IN_W-1:0] us_r;
  logic        [1:0]               zero_r;

  logic        [N:0]    vld [2];
  logic signed [CW-1:0] cx  [2][N+1];
  logic signed [CW-1:0] cy  [2][N+1];
  logic signed [ZW-1:0] cz  [2][N+1];

  logic signed [AW-1:0]            est      [2];
  logic        [1:0]               lane_done;

  genvar l, i;
  generate
    for (l = 0; l < 2; l++) begin : g_lane
      logic signed [CW-1:0]           xs, ys, x0, y0;
      logic signed [ZW-1:0]           z0;
      logic signed [ZXW-1:0]          zx, conv;
      logic signed [AW-1:0]           meas;
      logic signed [ctf_pkg::IN_W-1:0] term, ofs;

      // Scale by 2^24 and fold the left half plane onto the right one.
      assign xs = {{PADW{lane_x[l][ctf_pkg::IN_W-1]}}, lane_x[l],
                   {ctf_pkg::SCALE_SH{1'b0}}};
      assign ys = {{PADW{lane_y[l][ctf_pkg::IN_W-1]}}, lane_y[l],
                   {ctf_pkg::SCALE_SH{1'b0}}};

      always_comb begin
        if (xs[CW-1]) begin
          if (!ys[CW-1]) begin
            x0 = ys;
            y0 = -xs;
            z0 = Z90;
          end else begin
            x0 = -ys;
            y0 = xs;
            z0 = -Z90;
          end
        end else begin
          x0 = xs;
          y0 = ys;
          z0 = '0;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld[l][0] <= 1'b0;
        end else begin
          vld[l][0] <= in_acc;
        end
      end

      always_ff @(posedge clk) begin
        if (in_acc) begin
          cx[l][0]  <= x0;
          cy[l][0]  <= y0;
          cz[l][0]  <= z0;
          rate_r[l] <= lane_rate[l];
          zero_r[l] <= (lane_x[l] == '0) && (lane_y[l] == '0);
        end
      end

      // Row of CORDIC cells, one iteration per cell.
      for (i = 0; i < N; i++) begin : g_cell
        ctf_cordic_cell #(
          .STAGE (i),
          .CW    (CW),
          .ZW    (ZW),
          .FRAC  (ANGLE_FRAC_BITS)
        ) u_cell (
          .clk     (clk),
          .rst_n   (rst_n),
          .in_vld  (vld[l][i]),
          .x_in    (cx[l][i]),
          .y_in    (cy[l][i]),
          .z_in    (cz[l][i]),
          .out_vld (vld[l][i+1]),
          .x_out   (cx[l][i+1]),
          .y_out   (cy[l][i+1]),
          .z_out   (cz[l][i+1])
        );
      end

      // Convert the accumulated angle to Q8.8; atan2(0, 0) reads as zero.
      assign zx   = {{8{cz[l][N][ZW-1]}}, cz[l][N]};
      assign conv = ((zx + ZXW'(HALF)) >>> S_DN) <<< S_UP;
      assign meas = zero_r[l] ? '0 : conv[AW-1:0];

      ctf_gyro u_gyro (
        .clk  (clk),
        .rate (rate_r[l]),
        .us   (us_r),
        .term (term)
      );

      // Roll integrates +rate, pitch integrates -rate.
      assign ofs = (l == 0) ? term : -term;

      ctf_blend u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (vld[l][N]),
        .weight   (gyro_weight_r),
        .pred_ofs (ofs),
        .meas     (meas),
        .est      (est[l]),
        .done     (lane_done[l])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (in_acc) begin
      us_r <= in_chan.elapsed_us;
    end
  end

  // ---------------------------------------------------------------------
  // Output register and alarm.
  // ---------------------------------------------------------------------
  logic                 out_valid_r, out_alarm_r;
  logic signed [AW-1:0] out_roll_r, out_pitch_r;
  logic        [AW-1:0] roll_mag, pitch_mag;
  logic                 alarm;

  assign roll_mag  = est[0][AW-1] ? AW'(-est[0]) : AW'(est[0]);
  assign pitch_mag = est[1][AW-1] ? AW'(-est[1]) : AW'(est[1]);
  assign alarm     = (roll_mag > {1'b0, tilt_limit_r}) || (pitch_mag > {1'b0, tilt_limit_r});

  assign out_load = res_pend_r && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (out_load) begin
        busy_r <= 1'b0;
      end
      if (lane_done[0]) begin
        res_pend_r <= 1'b1;
      end else if (out_load) begin
        res_pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_roll_r  <= est[0];
      out_pitch_r <= est[1];
      out_alarm_r <= alarm;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.roll_angle  = out_roll_r;
  assign out_chan.pitch_angle = out_pitch_r;
  assign out_chan.tilt_alarm  = out_alarm_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // Only one sample travels down the CORDIC row at a time.
  a_one_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(vld[0]))
    else $error("more than one sample in the CORDIC row");

  // A sample leaving the row belongs to an open request.
  a_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
    vld[0][N] |-> busy_r)
    else $error("CORDIC row output without an open request");

  // A finished estimate never overwrites one not yet moved to the output.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done[0] |-> !res_pend_r)
    else $error("blend result overran a pending result");

  // Roll and pitch lanes advance in lockstep.
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (vld[0] == vld[1]) && (lane_done[0] == lane_done[1]))
    else $error("roll and pitch lanes out of step");

endmodule

[rtl/ctf_cordic_cell.sv]
// One vectoring CORDIC iteration; a row of these forms the atan2 chain.
// Depends on ctf_pkg for the arctangent table.
module ctf_cordic_cell #(
  parameter int STAGE = 0,
  parameter int CW    = 43,
  parameter int ZW    = 18,
  parameter int FRAC  = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic                 out_vld,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out,
  output logic signed [ZW-1:0] z_out
);

  localparam int TS   = ctf_pkg::ATAN_FRAC - FRAC;
  localparam int STEP = (ctf_pkg::atan_q20(STAGE) + (1 << (TS - 1))) >> TS;
  localparam logic signed [ZW-1:0] STEP_Z = ZW'(STEP);

  logic                 vld_r;
  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic signed [CW-1:0] dx, dy;

  assign dx = y_in >>> STAGE;
  assign dy = x_in >>> STAGE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  // Rotate toward the x axis: direction set by the sign of y.
  always_ff @(posedge clk) begin
    if (in_vld) begin
      if (!y_in[CW-1]) begin
        x_r <= x_in + dx;
        y_r <= y_in - dy;
        z_r <= z_in + STEP_Z;
      end else begin
        x_r <= x_in - dx;
        y_r <= y_in + dy;
        z_r <= z_in - STEP_Z;
      end
    end
  end

  assign out_vld = vld_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign z_out   = z_r;

endmodule

[rtl/ctf_gyro.sv]
// Gyro increment: rate * elapsed_us / 250000, rounded half away from zero.
// Three register stages, reciprocal multiply with one correction; uses ctf_pkg.
module ctf_gyro (
  input  logic                            clk,
  input  logic signed [ctf_pkg::IN_W-1:0] rate,
  input  logic        [ctf_pkg::IN_W-1:0] us,
  output logic signed [ctf_pkg::IN_W-1:0] term
);

  logic        [15:0] rate_mag;
  logic        [31:0] mag_r;
  logic               neg1_r, neg2_r;
  logic        [31:0] num;
  logic        [27:0] npre;
  logic        [56:0] prod;
  logic        [27:0] np_r;
  logic        [14:0] q0_r;
  logic        [27:0] qmul;
  logic        [27:0] rem;
  logic        [14:0] q;
  logic signed [ctf_pkg::IN_W-1:0] term_r;

  // |rate| fits 16 unsigned bits, including the most negative code.
  assign rate_mag = rate[15] ? 16'(-rate) : rate;

  always_ff @(posedge clk) begin
    mag_r  <= 32'(rate_mag) * 32'(us);
    neg1_r <= rate[15];
  end

  assign num  = mag_r + 32'(ctf_pkg::GYRO_ROUND);
  assign npre = num[31:ctf_pkg::GYRO_PRE_SH];
  assign prod = 57'(npre) * 57'(ctf_pkg::GYRO_RECIP);

  always_ff @(posedge clk) begin
    np_r   <= npre;
    q0_r   <= prod[ctf_pkg::GYRO_RECIP_SH +: 15];
    neg2_r <= neg1_r;
  end

  // Estimate is at most one low: fix it with a single compare.
  assign qmul = 28'(q0_r) * 28'(ctf_pkg::GYRO_DIV);
  assign rem  = np_r - qmul;
  assign q    = (rem >= 28'(ctf_pkg::GYRO_DIV)) ? q0_r + 15'd1 : q0_r;

  always_ff @(posedge clk) begin
    term_r <= neg2_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

  assign term = term_r;

endmodule

[rtl/ctf_blend.sv]
// One blend lane: holds an angle estimate and mixes prediction with measurement.
// Two stages (multiply, then round and clamp); uses ctf_pkg.
module ctf_blend (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               fire,
  input  logic        [ctf_pkg::CFG_DATA_W-1:0] weight,
  input  logic signed [ctf_pkg::IN_W-1:0]    pred_ofs,
  input  logic signed [ctf_pkg::ANG_W-1:0]   meas,
  output logic signed [ctf_pkg::ANG_W-1:0]   est,
  output logic                               done
);

  localparam logic signed [20:0] MAX_V = 21'(ctf_pkg::ANGLE_MAX);

  logic signed [ctf_pkg::ANG_W-1:0] est_r;
  logic                             fire_b_r;
  logic signed [17:0]               pred;
  logic        [16:0]               acc_w;
  logic signed [35:0]               pw_r, pm_r;
  logic signed [36:0]               sum;
  logic signed [20:0]               v;
  logic signed [ctf_pkg::ANG_W-1:0] est_nxt;

  assign pred  = 18'(est_r) + 18'(pred_ofs);
  assign acc_w = 17'h10000 - {1'b0, weight};

  always_ff @(posedge clk) begin
    if (fire) begin
      pw_r <= $signed({2'b00, weight}) * pred;
      pm_r <= $signed({1'b0, acc_w}) * 18'(meas);
    end
  end

  assign sum = 37'(pw_r) + 37'(pm_r) + 37'sd32768;
  assign v   = sum[36:16];

  always_comb begin
    if (v > MAX_V) begin
      est_nxt = ctf_pkg::ANG_W'(ctf_pkg::ANGLE_MAX);
    end else if (v < -MAX_V) begin
      est_nxt = -ctf_pkg::ANG_W'(ctf_pkg::ANGLE_MAX);
    end else begin
      est_nxt = v[ctf_pkg::ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fire_b_r <= 1'b0;
      est_r    <= '0;
    end else begin
      fire_b_r <= fire;
      if (fire_b_r) begin
        est_r <= est_nxt;
      end
    end
  end

  assign est  = est_r;
  assign done = fire_b_r;

endmodule
